@@ design/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// No dependencies.
package spq_pkg;
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FN_ENQ   = 2'd0,
    FN_DEQ   = 2'd1,
    FN_NUDGE = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request
    logic search;  // run id search and compare cells
    logic apply;   // commit the update
  } dp_cmd_t;

  // datapath -> controller (none needed beyond timing)
  typedef struct packed {
    logic busy;
  } dp_sts_t;
endpackage

@@ design/spq_ctrl.sv @@
// Controller state machine for the stable priority queue.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output spq_pkg::dp_cmd_t cmd,
  input  spq_pkg::dp_sts_t sts
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_APPLY  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   apply_ok;

  // result register free, or emptied at this edge
  assign apply_ok   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign cmd.load   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.search = (state_r == S_SEARCH);
  assign cmd.apply  = (state_r == S_APPLY) && apply_ok;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_SEARCH;
      S_SEARCH: state_nxt = S_APPLY;
      S_APPLY:  if (apply_ok) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.apply)       out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search |=> state_r == S_APPLY)
    else $error("search not followed by apply");
  a_outv: assert property (@(posedge clk) disable iff (!rst_n) cmd.apply |=> out_tvalid)
    else $error("apply not followed by result");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) cmd.search |-> sts.busy)
    else $error("search without a captured request");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");
endmodule

@@ design/spq_dp.sv @@
// Datapath: slot stores, parallel match/compare cells, shift update.
// Depends on spq_pkg.
module spq_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  spq_pkg::dp_cmd_t        cmd,
  output spq_pkg::dp_sts_t        sts,
  input  logic [1:0]              req_func,
  input  logic [15:0]             req_id,
  input  logic [15:0]             req_prio,
  output logic [1:0]              res_status,
  output logic                    res_fvalid,
  output logic [15:0]             res_fid,
  output logic [15:0]             res_fprio,
  output logic [4:0]              res_count
);
  import spq_pkg::*;

  logic [15:0] sid_r [DEPTH];
  logic [15:0] spr_r [DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]  fn_r;
  logic [15:0] id_r, pr_r;
  logic [DEPTH-1:0] hit_r;   // slot holds the id
  logic [DEPTH-1:0] gt_r;    // slot priority > request, post-removal order
  logic        found_r;
  logic [IDX_W-1:0] pos_r;
  logic        busy_r;
  // result register
  logic [1:0]  st_r;
  logic        fv_r;
  logic [15:0] fid_r, fpr_r;
  logic [4:0]  ocnt_r;

  // search cells
  logic [DEPTH-1:0] hit_c, gtraw_c, gt_c;
  logic             found_c;
  logic [IDX_W-1:0] pos_c;
  always_comb begin
    found_c = 1'b0;
    pos_c   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_c[i]   = (i < int'(cnt_r)) && (sid_r[i] == id_r);
      gtraw_c[i] = (pr_r < spr_r[i]);
    end
    for (int i = DEPTH - 1; i >= 0; i--)
      if (hit_c[i]) begin
        found_c = 1'b1;
        pos_c   = IDX_W'(i);
      end
    // compare flags in post-removal index space
    for (int i = 0; i < DEPTH; i++) begin
      if (found_c && i >= int'(pos_c))
        gt_c[i] = (i + 1 < DEPTH) ? gtraw_c[(i + 1) % DEPTH] : 1'b0;
      else
        gt_c[i] = gtraw_c[i];
    end
  end

  // update cells
  logic [15:0] nid [DEPTH];
  logic [15:0] npr [DEPTH];
  logic [CNT_W-1:0] ncnt, rcnt;
  logic [1:0] nst;
  logic [15:0] rid [DEPTH];
  logic [15:0] rpr [DEPTH];
  logic [DEPTH-1:0] ins_at;
  logic placed;
  always_comb begin
    nst    = ST_OK;
    ncnt   = cnt_r;
    rcnt   = cnt_r;
    placed = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      nid[i] = sid_r[i];
      npr[i] = spr_r[i];
      // after removal of the matched slot
      if (found_r && i >= int'(pos_r) && i + 1 < DEPTH) begin
        rid[i] = sid_r[(i + 1) % DEPTH];
        rpr[i] = spr_r[(i + 1) % DEPTH];
      end else begin
        rid[i] = sid_r[i];
        rpr[i] = spr_r[i];
      end
    end
    if (found_r) rcnt = cnt_r - 1'b1;
    // insertion point: first valid slot with larger priority, else rcnt
    for (int i = 0; i < DEPTH; i++)
      ins_at[i] = (i < int'(rcnt)) && gt_r[i];
    case (func_t'(fn_r))
      FN_ENQ: begin
        if (!found_r && cnt_r >= CNT_W'(DEPTH)) nst = ST_FULL;
        else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!placed && (ins_at[i] || i == int'(rcnt))) begin
              nid[i] = id_r; npr[i] = pr_r;
              placed = 1'b1;
            end else if (placed) begin
              // slots behind the new entry move back one place
              nid[i] = rid[(i + DEPTH - 1) % DEPTH];
              npr[i] = rpr[(i + DEPTH - 1) % DEPTH];
            end else begin
              nid[i] = rid[i]; npr[i] = rpr[i];
            end
          end
          ncnt = rcnt + 1'b1;
        end
      end
      FN_DEQ: begin
        if (cnt_r == '0) nst = ST_EMPTY;
        else begin
          for (int i = 0; i + 1 < DEPTH; i++) begin
            nid[i] = sid_r[i + 1]; npr[i] = spr_r[i + 1];
          end
          ncnt = cnt_r - 1'b1;
        end
      end
      FN_NUDGE: begin
        if (!found_r) nst = ST_NOTFOUND;
        else if (pos_r != '0) begin
          nid[pos_r - 1'b1] = id_r;
          nid[pos_r]        = sid_r[pos_r - 1'b1];
          npr[pos_r]        = spr_r[pos_r - 1'b1];
        end
      end
      FN_CLEAR: ncnt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_r <= req_func; id_r <= req_id; pr_r <= req_prio;
    end
    if (cmd.search) begin
      hit_r <= hit_c; gt_r <= gt_c; found_r <= found_c; pos_r <= pos_c;
    end
    if (cmd.apply) begin
      for (int i = 0; i < DEPTH; i++) begin
        sid_r[i] <= nid[i];
        spr_r[i] <= npr[i];
      end
      st_r   <= nst;
      fv_r   <= (ncnt != '0);
      fid_r  <= (ncnt != '0) ? nid[0] : 16'd0;
      fpr_r  <= (ncnt != '0) ? npr[0] : 16'd0;
      ocnt_r <= 5'(ncnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (cmd.apply) cnt_r <= ncnt;
      busy_r <= cmd.load | cmd.search;
    end
  end

  assign sts.busy   = busy_r;
  assign res_status = st_r;
  assign res_fvalid = fv_r;
  assign res_fid    = fid_r;
  assign res_fprio  = fpr_r;
  assign res_count  = ocnt_r;

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(DEPTH))
    else $error("count overflow");
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> $countones(hit_r) <= 1) else $error("hit vector corrupt");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && nst == ST_FULL) |=> $stable(cnt_r)) else $error("full changed count");
endmodule

@@ design/stable_priority_queue_top.sv @@
// Top level of the stable priority queue.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Bounded priority queue of up to DEPTH (16) (id, priority) entries ordered
// low priority first, equal priorities in arrival order. Each input beat
// carries one command; exactly one result beat follows it with the status and
// the front entry and count after the command. After the accepting edge the
// command runs a search step (parallel id-match and priority compare across
// all slots) and then the shift update of the slot registers, which also loads
// the result register and waits while that register holds a result not yet taken.
// The next beat is taken the cycle after the update, so a new command is not
// taken before the last one is through. A result left waiting for out_tready
// does not block the next beat; only the update of the following command waits
// until the result register is taken.
module stable_priority_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // func[1:0], id[17:2], priority_req[33:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], front_valid[2], front_id[18:3],
                                  // front_priority[34:19], entry_count[39:35]
);
  import spq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [1:0]  st;
  logic        fv;
  logic [15:0] fid, fpr;
  logic [4:0]  cnt;

  spq_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts
  );

  spq_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .req_func  (in_tdata[1:0]),
    .req_id    (in_tdata[17:2]),
    .req_prio  (in_tdata[33:18]),
    .res_status(st),
    .res_fvalid(fv),
    .res_fid   (fid),
    .res_fprio (fpr),
    .res_count (cnt)
  );

  assign out_tdata = {cnt, fpr, fid, fv, st};
endmodule
